FILE: rtl/fmtc_pkg.sv
// Package: signature table, pattern constants and shared types for the file type classifier.
package fmtc_pkg;

	localparam int NUM_SIGS = 52;
	localparam int NUM_PATS = 10;
	localparam int HDR_LEN = 12;
	localparam int SIG_MAX_LEN = 16;
	localparam int POS_W = 16;
	localparam logic [POS_W-1:0] POS_MAX = 16'hFFFF;
	localparam int ZIP_SEARCH_BYTES_DEF = 8192;
	localparam int WEBM_SEARCH_BYTES_DEF = 64;
	localparam int HISTORY_DEPTH_DEF = 48;
	localparam int PAT_WEBM = 9;

	typedef struct packed {
		logic [16:0] off;
		logic [4:0] len;
		logic [6:0] conf;
		logic [5:0] ftype;
		logic [3:0] cat;
		logic [127:0] m; // byte k at [8k+7:8k]
	} sig_t;

	typedef struct packed {
		logic [5:0] ftype;
		logic [3:0] cat;
		logic [6:0] conf;
	} result_t;

	// Header snapshot, search flags, live signature mask and file length handed to the resolve stage
	typedef struct packed {
		logic [HDR_LEN*8-1:0] hdr;
		logic [NUM_PATS-1:0] seen;
		logic [NUM_SIGS-1:0] alive;
		logic [POS_W:0] flen;
	} scan_t;

	function automatic logic [127:0] mb(input logic [127:0] be, input int n);
		logic [127:0] r;
		r = '0;
		for (int k = 0; k < 16; k++)
			if (k < n) r[8*k +: 8] = be[8*(15-k) +: 8];
		return r;
	endfunction

	function automatic sig_t mk(input int off, input int len, input int conf,
			input int ft, input int cat, input logic [127:0] be);
		sig_t s;
		s.off = 17'(off);
		s.len = 5'(len);
		s.conf = 7'(conf);
		s.ftype = 6'(ft);
		s.cat = 4'(cat);
		s.m = mb(be, len);
		return s;
	endfunction

	function automatic sig_t sig(input int i);
		sig_t s;
		unique case (i)
			0: s = mk(0, 4, 95, 1, 1, 128'h25504446 << 96);
			1: s = mk(0, 5, 95, 2, 1, 128'h7B5C727466 << 88);
			2: s = mk(0, 8, 80, 3, 1, 128'hD0CF11E0A1B11AE1 << 64);
			3: s = mk(0, 4, 70, 4, 7, 128'h504B0304 << 96);
			4: s = mk(0, 3, 95, 5, 4, 128'hFFD8FF << 104);
			5: s = mk(0, 8, 95, 6, 4, 128'h89504E470D0A1A0A << 64);
			6: s = mk(0, 6, 95, 7, 4, 128'h474946383761 << 80);
			7: s = mk(0, 6, 95, 8, 4, 128'h474946383961 << 80);
			8: s = mk(0, 2, 85, 9, 4, 128'h424D << 112);
			9: s = mk(0, 4, 95, 10, 4, 128'h49492A00 << 96);
			10: s = mk(0, 4, 95, 10, 4, 128'h4D4D002A << 96);
			11: s = mk(0, 4, 60, 11, 0, 128'h52494646 << 96);
			12: s = mk(0, 4, 85, 12, 4, 128'h00000100 << 96);
			13: s = mk(0, 4, 95, 13, 4, 128'h38425053 << 96);
			14: s = mk(0, 3, 90, 14, 5, 128'h494433 << 104);
			15: s = mk(0, 2, 75, 14, 5, 128'hFFFB << 112);
			16: s = mk(0, 4, 95, 15, 5, 128'h664C6143 << 96);
			17: s = mk(0, 4, 90, 16, 5, 128'h4F676753 << 96);
			18: s = mk(0, 2, 75, 17, 5, 128'hFFF1 << 112);
			19: s = mk(0, 4, 85, 18, 6, 128'h1A45DFA3 << 96);
			20: s = mk(0, 4, 95, 19, 6, 128'h464C5601 << 96);
			21: s = mk(4, 4, 90, 20, 6, 128'h66747970 << 96);
			22: s = mk(0, 8, 95, 21, 7, 128'h526172211A070100 << 64);
			23: s = mk(0, 7, 95, 22, 7, 128'h526172211A0700 << 72);
			24: s = mk(0, 6, 95, 23, 7, 128'h377ABCAF271C << 80);
			25: s = mk(257, 5, 90, 24, 7, 128'h7573746172 << 88);
			26: s = mk(0, 2, 95, 25, 7, 128'h1F8B << 112);
			27: s = mk(0, 3, 95, 26, 7, 128'h425A68 << 104);
			28: s = mk(0, 6, 95, 27, 7, 128'hFD377A585A00 << 80);
			29: s = mk(0, 4, 95, 28, 7, 128'h28B52FFD << 96);
			30: s = mk(0, 2, 90, 29, 8, 128'h4D5A << 112);
			31: s = mk(0, 4, 95, 30, 8, 128'h7F454C46 << 96);
			32: s = mk(0, 4, 95, 31, 8, 128'hFEEDFACE << 96);
			33: s = mk(0, 4, 95, 32, 8, 128'hFEEDFACF << 96);
			34: s = mk(0, 4, 95, 33, 8, 128'hCEFAEDFE << 96);
			35: s = mk(0, 4, 95, 34, 8, 128'hCFFAEDFE << 96);
			36: s = mk(0, 4, 85, 35, 8, 128'hCAFEBABE << 96);
			37: s = mk(0, 2, 70, 36, 9, 128'h2321 << 112);
			38: s = mk(0, 16, 95, 37, 10, 128'h53514C69746520666F726D6174203300);
			39: s = mk(0, 16, 90, 38, 10, 128'h000100005374616E64617264204A6574);
			40: s = mk(0, 5, 80, 39, 11, 128'h0001000000 << 88);
			41: s = mk(0, 4, 95, 40, 11, 128'h4F54544F << 96);
			42: s = mk(0, 4, 95, 41, 11, 128'h774F4646 << 96);
			43: s = mk(0, 4, 95, 42, 11, 128'h774F4632 << 96);
			44: s = mk(0, 4, 95, 43, 12, 128'h41433130 << 96);
			45: s = mk(0, 4, 95, 44, 8, 128'h0061736D << 96);
			46: s = mk(0, 4, 95, 45, 7, 128'h04224D18 << 96);
			47: s = mk(0, 4, 80, 46, 8, 128'hCAFEBABE << 96);
			48: s = mk(32769, 5, 90, 47, 7, 128'h4344303031 << 88);
			49: s = mk(0, 8, 90, 48, 8, 128'h4C00000001140200 << 64);
			50: s = mk(0, 4, 80, 49, 4, 128'h0A050108 << 96);
			default: s = mk(0, 4, 95, 50, 5, 128'h4D546864 << 96);
		endcase
		return s;
	endfunction

	// Signatures that outrank signature i: higher confidence, then longer, then earlier
	function automatic logic [NUM_SIGS-1:0] beats_mask(input int i);
		logic [NUM_SIGS-1:0] r;
		sig_t a, b;
		r = '0;
		a = sig(i);
		for (int j = 0; j < NUM_SIGS; j++) begin
			b = sig(j);
			if (b.conf > a.conf || (b.conf == a.conf
					&& (b.len > a.len || (b.len == a.len && j < i))))
				r[j] = 1'b1;
		end
		return r;
	endfunction

	localparam int PAT_MAX = 47;

	function automatic int pat_len(input int i);
		unique case (i)
			0: return 5;
			1: return 3;
			2: return 4;
			3: return 9;
			4: return 11;
			5: return 8;
			6: return 39;
			7: return 46;
			8: return 47;
			default: return 4;
		endcase
	endfunction

	// Pattern text, right aligned: first character at byte pat_len-1, zero padded above
	function automatic logic [PAT_MAX*8-1:0] pat_str(input int i);
		unique case (i)
			0: return (PAT_MAX*8)'("word/");
			1: return (PAT_MAX*8)'("xl/");
			2: return (PAT_MAX*8)'("ppt/");
			3: return (PAT_MAX*8)'("META-INF/");
			4: return (PAT_MAX*8)'("classes.dex");
			5: return (PAT_MAX*8)'("mimetype");
			6: return (PAT_MAX*8)'("application/vnd.oasis.opendocument.text");
			7: return (PAT_MAX*8)'("application/vnd.oasis.opendocument.spreadsheet");
			8: return (PAT_MAX*8)'("application/vnd.oasis.opendocument.presentation");
			default: return (PAT_MAX*8)'("webm");
		endcase
	endfunction

endpackage

FILE: rtl/fmtc_scan.sv
// Scan stage: per-byte signature compare, header capture, history window and substring search.
module fmtc_scan #(
	parameter int ZIP_SEARCH_BYTES = fmtc_pkg::ZIP_SEARCH_BYTES_DEF,
	parameter int WEBM_SEARCH_BYTES = fmtc_pkg::WEBM_SEARCH_BYTES_DEF,
	parameter int HISTORY_DEPTH = fmtc_pkg::HISTORY_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic take,
	input logic [7:0] byte_in,
	input logic last_in,
	output fmtc_pkg::scan_t scan
);
	localparam int PW = fmtc_pkg::POS_W;

	logic [PW-1:0] pos_q;
	logic [fmtc_pkg::NUM_SIGS-1:0] alive_q, alive_nx;
	logic [fmtc_pkg::HDR_LEN*8-1:0] hdr_q, hdr_nx;
	logic [HISTORY_DEPTH*8-1:0] hist_q, hist_nx; // byte 0 newest
	logic [fmtc_pkg::NUM_PATS-1:0] seen_q, seen_nx;

	always_comb begin
		fmtc_pkg::sig_t s;
		logic [16:0] rel;
		int m;
		logic eq;
		logic [fmtc_pkg::PAT_MAX*8-1:0] ps;
		alive_nx = alive_q;
		for (int i = 0; i < fmtc_pkg::NUM_SIGS; i++) begin
			s = fmtc_pkg::sig(i);
			rel = 17'(pos_q) - s.off;
			if ({1'b0, pos_q} >= s.off && rel < 17'(s.len)
					&& byte_in != s.m[8*rel[3:0] +: 8])
				alive_nx[i] = 1'b0;
		end
		hdr_nx = hdr_q;
		for (int j = 0; j < fmtc_pkg::HDR_LEN; j++)
			if (pos_q == PW'(j)) hdr_nx[8*j +: 8] = byte_in;
		hist_nx = {hist_q[(HISTORY_DEPTH-1)*8-1:0], byte_in};
		seen_nx = seen_q;
		for (int i = 0; i < fmtc_pkg::NUM_PATS; i++) begin
			m = fmtc_pkg::pat_len(i);
			ps = fmtc_pkg::pat_str(i);
			eq = (32'(pos_q) + 1 >= m) && (32'(pos_q) <
				((i == fmtc_pkg::PAT_WEBM) ? WEBM_SEARCH_BYTES : ZIP_SEARCH_BYTES));
			for (int k = 0; k < fmtc_pkg::PAT_MAX; k++)
				if (k < m && hist_nx[8*(m-1-k) +: 8] != ps[8*(m-1-k) +: 8]) eq = 1'b0;
			if (eq) seen_nx[i] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			alive_q <= '1;
			hdr_q <= '0;
			hist_q <= '0;
			seen_q <= '0;
		end else if (take) begin
			if (last_in) begin
				pos_q <= '0;
				alive_q <= '1;
				hdr_q <= '0;
				hist_q <= '0;
				seen_q <= '0;
			end else begin
				if (pos_q != fmtc_pkg::POS_MAX) pos_q <= pos_q + 1'b1;
				alive_q <= alive_nx;
				hdr_q <= hdr_nx;
				hist_q <= hist_nx;
				seen_q <= seen_nx;
			end
		end
	end

	assign scan.hdr = hdr_nx;
	assign scan.seen = seen_nx;
	assign scan.alive = alive_nx;
	assign scan.flen = {1'b0, pos_q} + 1'b1;
endmodule

FILE: rtl/fmtc_resolve.sv
// Resolve stage: pick the best live signature and apply container refinements.
module fmtc_resolve (
	input fmtc_pkg::scan_t scan,
	output fmtc_pkg::result_t res
);
	always_comb begin
		fmtc_pkg::sig_t s;
		logic [6:0] bconf, cconf;
		logic [5:0] btype, ctype;
		logic [3:0] bcat, ccat;
		logic [31:0] h0, h8;
		logic [fmtc_pkg::NUM_SIGS-1:0] elig, win;
		bconf = '0; btype = '0; bcat = '0;
		cconf = '0; ctype = '0; ccat = '0;
		for (int i = 0; i < fmtc_pkg::NUM_SIGS; i++) begin
			s = fmtc_pkg::sig(i);
			elig[i] = scan.alive[i] && (18'(s.off) + 18'(s.len) <= 18'(scan.flen));
		end
		// one-hot winner: eligible and not outranked by any other eligible signature
		for (int i = 0; i < fmtc_pkg::NUM_SIGS; i++)
			win[i] = elig[i] && !(|(elig & fmtc_pkg::beats_mask(i)));
		for (int i = 0; i < fmtc_pkg::NUM_SIGS; i++) begin
			s = fmtc_pkg::sig(i);
			if (win[i]) begin
				btype = btype | s.ftype;
				bcat = bcat | s.cat;
				bconf = bconf | s.conf;
			end
		end
		h0 = {scan.hdr[7:0], scan.hdr[15:8], scan.hdr[23:16], scan.hdr[31:24]};
		h8 = {scan.hdr[71:64], scan.hdr[79:72], scan.hdr[87:80], scan.hdr[95:88]};
		if (scan.flen >= 4 && h0 == 32'h504B0304) begin
			priority if (scan.seen[0]) begin ctype = 51; ccat = 1; cconf = 95; end
			else if (scan.seen[1]) begin ctype = 52; ccat = 2; cconf = 95; end
			else if (scan.seen[2]) begin ctype = 53; ccat = 3; cconf = 95; end
			else if (scan.seen[3]) begin
				if (scan.seen[4]) begin ctype = 54; ccat = 7; cconf = 90; end
				else begin ctype = 55; ccat = 7; cconf = 85; end
			end else if (scan.seen[5]) begin
				if (scan.seen[6]) begin ctype = 56; ccat = 1; cconf = 95; end
				else if (scan.seen[7]) begin ctype = 57; ccat = 2; cconf = 95; end
				else if (scan.seen[8]) begin ctype = 58; ccat = 3; cconf = 95; end
			end
		end else if (scan.flen >= 12 && h0 == 32'h52494646) begin
			if (h8 == "WEBP") begin ctype = 59; ccat = 4; cconf = 95; end
			else if (h8 == "WAVE") begin ctype = 60; ccat = 5; cconf = 95; end
			else if (h8 == "AVI ") begin ctype = 61; ccat = 6; cconf = 95; end
		end else if (scan.flen >= 4 && h0 == 32'h1A45DFA3) begin
			if (scan.seen[fmtc_pkg::PAT_WEBM]) begin ctype = 62; ccat = 6; cconf = 95; end
			else begin ctype = 18; ccat = 6; cconf = 90; end
		end
		if (cconf > bconf) begin btype = ctype; bcat = ccat; bconf = cconf; end
		res.ftype = btype;
		res.cat = bcat;
		res.conf = bconf;
	end
endmodule

FILE: rtl/file_magic_type_classifier.sv
// Top level: streaming file type classifier by magic bytes.
// The result is registered on the clock edge that accepts the last byte.
// Throughput: one byte per cycle unless in_stall; result register frees as it is taken.
// Input stalls only while a result waits and another last byte arrives.
// Reset clears the position, match flags, header, history and result valid.
module file_magic_type_classifier #(
	parameter int ZIP_SEARCH_BYTES = fmtc_pkg::ZIP_SEARCH_BYTES_DEF,
	parameter int WEBM_SEARCH_BYTES = fmtc_pkg::WEBM_SEARCH_BYTES_DEF,
	parameter int HISTORY_DEPTH = fmtc_pkg::HISTORY_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] byte_value,
	input logic last_byte,
	output logic out_valid,
	input logic out_stall,
	output logic [5:0] type_code,
	output logic [3:0] category_code,
	output logic [6:0] confidence
);
	fmtc_pkg::scan_t scan;
	fmtc_pkg::result_t res;
	logic vld_q, take;

	assign in_stall = vld_q && out_stall && last_byte;
	assign take = in_valid && !in_stall;

	fmtc_scan #(
		.ZIP_SEARCH_BYTES(ZIP_SEARCH_BYTES),
		.WEBM_SEARCH_BYTES(WEBM_SEARCH_BYTES),
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_scan (
		.clk(clk), .arst_n(arst_n), .take(take),
		.byte_in(byte_value), .last_in(last_byte), .scan(scan)
	);

	fmtc_resolve u_resolve (.scan(scan), .res(res));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (take && last_byte) begin
			vld_q <= 1'b1;
		end else if (!out_stall) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && last_byte) begin
			type_code <= res.ftype;
			category_code <= res.cat;
			confidence <= res.conf;
		end
	end

	assign out_valid = vld_q;
endmodule

FILE: sim/file_magic_type_classifier_test.sv
// Testbench: file type classifier, each result checked against a behavioral predictor.
`timescale 1ns / 100ps

module file_magic_type_classifier_test;

	localparam int NSIG = 52;
	localparam int NPAT = 10;
	localparam int HIST = 48;
	localparam int ZIP_WIN = 8192;
	localparam int WEBM_WIN = 64;
	localparam int PAT_WEBM_IDX = 9;
	localparam int SIG_ISO = 48;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct {
		logic [7:0] b;
		logic last;
		logic typed;
		fmtc_pkg::result_t r;
	} beat_t;

	typedef struct {
		logic [7:0] b;
		logic last;
		logic [5:0] t;
		logic [3:0] c;
		logic [6:0] f;
	} dir_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [7:0] byte_value = 0;
	logic last_byte = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [5:0] type_code;
	logic [3:0] category_code;
	logic [6:0] confidence;

	file_magic_type_classifier dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// magic table, magic right aligned: byte k at [8*(len-1-k) +: 8]
	int sig_off[NSIG], sig_len[NSIG], sig_conf[NSIG], sig_type[NSIG], sig_cat[NSIG];
	logic [127:0] sig_magic[NSIG];
	string pat_text[NPAT] = '{"word/", "xl/", "ppt/", "META-INF/", "classes.dex", "mimetype",
		"application/vnd.oasis.opendocument.text",
		"application/vnd.oasis.opendocument.spreadsheet",
		"application/vnd.oasis.opendocument.presentation", "webm"};

	// predictor state
	int pos;
	bit alive[NSIG];
	logic [7:0] hdr[12];
	logic [7:0] hist[HIST];
	bit seen[NPAT];

	beat_t beat_q[$];
	beat_t cur_beat;
	fmtc_pkg::result_t result_q[$];
	logic [7:0] fbuf[$];

	int idle_in = 9, idle_out = 82;
	bit hold_req = 0, hold_taken = 0;
	int hold_left = 0;
	int errors = 0, n_bytes = 0, n_files = 0, n_results = 0, cycles = 0;
	bit type_hit[64];

	task automatic add_sig(input int i, input int off, input int len, input int conf,
			input int ft, input int cat, input logic [127:0] mg);
		sig_off[i] = off; sig_len[i] = len; sig_conf[i] = conf;
		sig_type[i] = ft; sig_cat[i] = cat; sig_magic[i] = mg;
	endtask

	function automatic logic [7:0] magic_byte(input int i, input int k);
		return sig_magic[i][8*(sig_len[i]-1-k) +: 8];
	endfunction

	task automatic clear_scan();
		pos = 0;
		foreach (alive[i]) alive[i] = 1;
		foreach (hdr[i]) hdr[i] = 0;
		foreach (hist[i]) hist[i] = 0;
		foreach (seen[i]) seen[i] = 0;
	endtask

	function automatic bit hdr_word(input logic [31:0] w, input int at);
		return {hdr[at], hdr[at+1], hdr[at+2], hdr[at+3]} == w;
	endfunction

	task automatic classify_byte(input logic [7:0] b, input logic last,
			output bit done, output fmtc_pkg::result_t res);
		int p, flen, m, lim, bconf, blen;
		bit eq;
		fmtc_pkg::result_t best, ref_r;
		p = pos;
		flen = p + 1;
		for (int i = 0; i < NSIG; i++)
			if (p >= sig_off[i] && p < sig_off[i] + sig_len[i]
					&& b != magic_byte(i, p - sig_off[i]))
				alive[i] = 0;
		if (p < 12) hdr[p] = b;
		for (int i = HIST - 1; i > 0; i--) hist[i] = hist[i-1];
		hist[0] = b;
		for (int i = 0; i < NPAT; i++) begin
			lim = (i == PAT_WEBM_IDX) ? WEBM_WIN : ZIP_WIN;
			m = pat_text[i].len();
			if (p >= lim || flen < m) continue;
			eq = 1;
			for (int k = 0; k < m; k++)
				if (hist[m-1-k] != pat_text[i][k]) eq = 0;
			if (eq) seen[i] = 1;
		end
		if (pos < 65535) pos++;
		done = last;
		res = '0;
		if (!last) return;
		best = '0; bconf = 0; blen = 0;
		for (int i = 0; i < NSIG; i++) begin
			if (!alive[i] || sig_off[i] + sig_len[i] > flen) continue;
			if (sig_conf[i] > bconf || (sig_conf[i] == bconf && sig_len[i] > blen)) begin
				best = '{6'(sig_type[i]), 4'(sig_cat[i]), 7'(sig_conf[i])};
				bconf = sig_conf[i]; blen = sig_len[i];
			end
		end
		ref_r = '0;
		if (flen >= 4 && hdr_word(32'h504B0304, 0)) begin
			if (seen[0]) ref_r = '{51, 1, 95};
			else if (seen[1]) ref_r = '{52, 2, 95};
			else if (seen[2]) ref_r = '{53, 3, 95};
			else if (seen[3]) ref_r = seen[4] ? '{54, 7, 90} : '{55, 7, 85};
			else if (seen[5]) begin
				if (seen[6]) ref_r = '{56, 1, 95};
				else if (seen[7]) ref_r = '{57, 2, 95};
				else if (seen[8]) ref_r = '{58, 3, 95};
			end
		end else if (flen >= 12 && hdr_word(32'h52494646, 0)) begin
			if (hdr_word("WEBP", 8)) ref_r = '{59, 4, 95};
			else if (hdr_word("WAVE", 8)) ref_r = '{60, 5, 95};
			else if (hdr_word("AVI ", 8)) ref_r = '{61, 6, 95};
		end else if (flen >= 4 && hdr_word(32'h1A45DFA3, 0)) begin
			ref_r = seen[PAT_WEBM_IDX] ? '{62, 6, 95} : '{18, 6, 90};
		end
		res = (ref_r.conf > best.conf) ? ref_r : best;
		clear_scan();
	endtask

	// sender: accept, predict, then offer the next beat
	always @(posedge clk) begin
		bit done;
		fmtc_pkg::result_t res;
		if (in_valid && !in_stall) begin
			classify_byte(byte_value, last_byte, done, res);
			if (done) result_q = {result_q, (cur_beat.typed ? cur_beat.r : res)};
		end
		if (!in_valid || !in_stall) begin
			if (beat_q.size() > 0 && $urandom_range(99) >= idle_in) begin
				cur_beat = beat_q.pop_front();
				in_valid <= 1;
				byte_value <= cur_beat.b;
				last_byte <= cur_beat.last;
			end else
				in_valid <= 0;
		end
	end

	// receiver: stall pattern and result check
	always @(posedge clk) begin
		fmtc_pkg::result_t e;
		if (hold_req && !hold_taken) begin
			hold_taken = 1;
			hold_left = 400;
		end
		if (out_valid && !out_stall) begin
			if (result_q.size() == 0) begin
				$display("%t unexpected result type %0d cat %0d conf %0d", $time,
					type_code, category_code, confidence);
				errors++;
			end else begin
				e = result_q.pop_front();
				n_results++;
				type_hit[type_code] = 1;
				if (type_code !== e.ftype) begin
					$display("%t type_code expected %0d got %0d", $time, e.ftype, type_code);
					errors++;
				end
				if (category_code !== e.cat) begin
					$display("%t category_code expected %0d got %0d", $time, e.cat,
						category_code);
					errors++;
				end
				if (confidence !== e.conf) begin
					$display("%t confidence expected %0d got %0d", $time, e.conf, confidence);
					errors++;
				end
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1;
		end else
			out_stall <= ($urandom_range(99) < idle_out);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("file_magic_type_classifier_test: FAIL");
			$finish;
		end
	end

	task automatic flush_file();
		beat_t bt;
		foreach (fbuf[i]) begin
			bt = '{fbuf[i], i == fbuf.size() - 1, 0, '0};
			beat_q = {beat_q, bt};
		end
		n_bytes += fbuf.size();
		n_files++;
		fbuf.delete();
	endtask

	task automatic add_text(input string s, input int at);
		for (int k = 0; k < s.len(); k++)
			if (at + k < fbuf.size()) fbuf[at + k] = s[k];
	endtask

	task automatic fill_random(input int n);
		repeat (n) fbuf = {fbuf, 8'($urandom)};
	endtask

	task automatic make_file();
		int kind, i, n, at;
		kind = $urandom_range(9);
		if (kind < 2) fill_random($urandom_range(1, 12));
		else if (kind < 5) begin
			i = $urandom_range(NSIG - 1);
			if (i == SIG_ISO) i = 0;
			n = sig_off[i] + sig_len[i];
			fill_random(n);
			for (int k = 0; k < sig_len[i]; k++) fbuf[sig_off[i] + k] = magic_byte(i, k);
			if ($urandom_range(4) == 0) fbuf[sig_off[i] + $urandom_range(sig_len[i]-1)] ^=
				8'(1 << $urandom_range(7));
			fill_random($urandom_range(5));
			if ($urandom_range(5) == 0) while (fbuf.size() > 1 && fbuf.size() >= n)
				void'(fbuf.pop_back());
		end else if (kind < 7) begin
			fill_random($urandom_range(8, 110));
			add_text("PK\003\004", 0);
			repeat ($urandom_range(2)) begin
				i = $urandom_range(8);
				at = $urandom_range(4, fbuf.size() - 1);
				add_text(pat_text[i], at);
				if ($urandom_range(3) == 0 && at < fbuf.size()) fbuf[at] ^= 8'h20;
			end
			if ($urandom_range(2) == 0) begin
				add_text("mimetype", 4);
				add_text(pat_text[$urandom_range(6, 8)], 20);
			end
		end else if (kind < 8) begin
			fill_random($urandom_range(3, 16));
			add_text("RIFF", 0);
			case ($urandom_range(3))
				0: add_text("WEBP", 8);
				1: add_text("WAVE", 8);
				2: add_text("AVI ", 8);
				default: ;
			endcase
		end else begin
			fill_random($urandom_range(4, 80));
			add_text("\032\105\337\243", 0);
			if ($urandom_range(1)) add_text("webm", $urandom_range(4, fbuf.size() - 1));
		end
		flush_file();
	endtask

	task automatic random_files(input int nb);
		int start;
		start = n_bytes;
		while (n_bytes - start < nb) make_file();
	endtask

	task automatic drain();
		do @(posedge clk);
		while (beat_q.size() > 0 || in_valid || result_q.size() > 0);
		repeat (5) @(posedge clk);
	endtask

	dir_row_t dir_tab[24] = '{
		'{8'h00, 1, 0, 0, 0},
		'{8'hFF, 1, 0, 0, 0},
		'{8'h25, 0, 0, 0, 0}, '{8'h50, 0, 0, 0, 0}, '{8'h44, 0, 0, 0, 0},
		'{8'h46, 1, 1, 1, 95},
		'{8'hFF, 0, 0, 0, 0}, '{8'hFB, 1, 14, 5, 75},
		'{8'h4D, 0, 0, 0, 0}, '{8'h5A, 1, 29, 8, 90},
		'{8'h50, 0, 0, 0, 0}, '{8'h4B, 0, 0, 0, 0}, '{8'h03, 0, 0, 0, 0},
		'{8'h04, 1, 4, 7, 70},
		'{8'h1A, 0, 0, 0, 0}, '{8'h45, 0, 0, 0, 0}, '{8'hDF, 0, 0, 0, 0},
		'{8'hA3, 1, 18, 6, 90},
		'{8'h23, 0, 0, 0, 0}, '{8'h21, 1, 36, 9, 70},
		'{8'hCA, 0, 0, 0, 0}, '{8'hFE, 0, 0, 0, 0}, '{8'hBA, 0, 0, 0, 0},
		'{8'hBE, 1, 35, 8, 85}
	};

	initial begin
		int ntypes;
		beat_t bt;
		add_sig(0, 0, 4, 95, 1, 1, 'h25504446);
		add_sig(1, 0, 5, 95, 2, 1, 'h7B5C727466);
		add_sig(2, 0, 8, 80, 3, 1, 'hD0CF11E0A1B11AE1);
		add_sig(3, 0, 4, 70, 4, 7, 'h504B0304);
		add_sig(4, 0, 3, 95, 5, 4, 'hFFD8FF);
		add_sig(5, 0, 8, 95, 6, 4, 'h89504E470D0A1A0A);
		add_sig(6, 0, 6, 95, 7, 4, 'h474946383761);
		add_sig(7, 0, 6, 95, 8, 4, 'h474946383961);
		add_sig(8, 0, 2, 85, 9, 4, 'h424D);
		add_sig(9, 0, 4, 95, 10, 4, 'h49492A00);
		add_sig(10, 0, 4, 95, 10, 4, 'h4D4D002A);
		add_sig(11, 0, 4, 60, 11, 0, 'h52494646);
		add_sig(12, 0, 4, 85, 12, 4, 'h00000100);
		add_sig(13, 0, 4, 95, 13, 4, 'h38425053);
		add_sig(14, 0, 3, 90, 14, 5, 'h494433);
		add_sig(15, 0, 2, 75, 14, 5, 'hFFFB);
		add_sig(16, 0, 4, 95, 15, 5, 'h664C6143);
		add_sig(17, 0, 4, 90, 16, 5, 'h4F676753);
		add_sig(18, 0, 2, 75, 17, 5, 'hFFF1);
		add_sig(19, 0, 4, 85, 18, 6, 'h1A45DFA3);
		add_sig(20, 0, 4, 95, 19, 6, 'h464C5601);
		add_sig(21, 4, 4, 90, 20, 6, 'h66747970);
		add_sig(22, 0, 8, 95, 21, 7, 'h526172211A070100);
		add_sig(23, 0, 7, 95, 22, 7, 'h526172211A0700);
		add_sig(24, 0, 6, 95, 23, 7, 'h377ABCAF271C);
		add_sig(25, 257, 5, 90, 24, 7, 'h7573746172);
		add_sig(26, 0, 2, 95, 25, 7, 'h1F8B);
		add_sig(27, 0, 3, 95, 26, 7, 'h425A68);
		add_sig(28, 0, 6, 95, 27, 7, 'hFD377A585A00);
		add_sig(29, 0, 4, 95, 28, 7, 'h28B52FFD);
		add_sig(30, 0, 2, 90, 29, 8, 'h4D5A);
		add_sig(31, 0, 4, 95, 30, 8, 'h7F454C46);
		add_sig(32, 0, 4, 95, 31, 8, 'hFEEDFACE);
		add_sig(33, 0, 4, 95, 32, 8, 'hFEEDFACF);
		add_sig(34, 0, 4, 95, 33, 8, 'hCEFAEDFE);
		add_sig(35, 0, 4, 95, 34, 8, 'hCFFAEDFE);
		add_sig(36, 0, 4, 85, 35, 8, 'hCAFEBABE);
		add_sig(37, 0, 2, 70, 36, 9, 'h2321);
		add_sig(38, 0, 16, 95, 37, 10, 'h53514C69746520666F726D6174203300);
		add_sig(39, 0, 16, 90, 38, 10, 'h000100005374616E64617264204A6574);
		add_sig(40, 0, 5, 80, 39, 11, 'h0001000000);
		add_sig(41, 0, 4, 95, 40, 11, 'h4F54544F);
		add_sig(42, 0, 4, 95, 41, 11, 'h774F4646);
		add_sig(43, 0, 4, 95, 42, 11, 'h774F4632);
		add_sig(44, 0, 4, 95, 43, 12, 'h41433130);
		add_sig(45, 0, 4, 95, 44, 8, 'h0061736D);
		add_sig(46, 0, 4, 95, 45, 7, 'h04224D18);
		add_sig(47, 0, 4, 80, 46, 8, 'hCAFEBABE);
		add_sig(48, 32769, 5, 90, 47, 7, 'h4344303031);
		add_sig(49, 0, 8, 90, 48, 8, 'h4C00000001140200);
		add_sig(50, 0, 4, 80, 49, 4, 'h0A050108);
		add_sig(51, 0, 4, 95, 50, 5, 'h4D546864);
		clear_scan();
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			bt = '{dir_tab[i].b, dir_tab[i].last, dir_tab[i].last,
				'{dir_tab[i].t, dir_tab[i].c, dir_tab[i].f}};
			beat_q = {beat_q, bt};
			n_bytes++;
			if (dir_tab[i].last) n_files++;
		end
		drain();
		random_files(190);
		drain();

		// long receiver hold-off while short files keep coming
		hold_req = 1;
		repeat (30) begin
			fill_random($urandom_range(1, 2));
			flush_file();
		end
		drain();

		idle_in = 82; idle_out = 9;
		random_files(190);
		drain();

		idle_in = 0; idle_out = 0;
		random_files(190);
		drain();

		ntypes = 0;
		foreach (type_hit[i]) ntypes += type_hit[i];
		$display("covered %0d bytes in %0d files, %0d results compared, %0d distinct types",
			n_bytes, n_files, n_results, ntypes);
		if (errors == 0)
			$display("file_magic_type_classifier_test: PASS");
		else
			$display("file_magic_type_classifier_test: FAIL");
		$finish;
	end

endmodule

FILE: sim.f
rtl/fmtc_pkg.sv
rtl/fmtc_scan.sv
rtl/fmtc_resolve.sv
rtl/file_magic_type_classifier.sv
sim/file_magic_type_classifier_test.sv
